// File: rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
// Used by the channel interfaces, the top level and the checker.
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PATTERN_BYTES = 16;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_INDEX_W   = 3;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned BASE_W        = 48;
  localparam int unsigned MATCH_ADDR_W  = 48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_CARE_MASK      = 3'd2,
    CFG_PATTERN_LENGTH = 3'd3,
    CFG_BASE_ADDRESS   = 3'd4
  } cfg_reg_e;

  localparam logic [PATTERN_BYTES-1:0] CARE_MASK_RESET      = 16'hFFFF;
  localparam logic [LEN_W-1:0]         PATTERN_LENGTH_RESET = 5'd1;

endpackage

// File: rtl/wbps_if.sv
// Valid/ready channel interfaces for the byte stream and the scan results.
// Depends on wbps_pkg for field widths.
`timescale 1ns / 1ps

interface wbps_byte_if;
  logic                        valid;
  logic                        ready;
  logic [wbps_pkg::BYTE_W-1:0] data_byte;
  logic                        last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface wbps_result_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [wbps_pkg::MATCH_ADDR_W-1:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input valid, found, match_address, output ready);
endinterface

// File: rtl/wildcard_byte_pattern_scanner_top.sv
// Top level of the wildcard byte pattern scanner: window, masked compare and result pipeline.
// Depends on wbps_pkg and the channel interfaces in wbps_if.sv.
`timescale 1ns / 1ps

// The block scans a byte stream for a pattern of up to MAX_PATTERN bytes with per-byte
// wildcards. Bytes arrive on byte_in, one request per byte, with last_byte marking the end
// of a region. Each region yields at most one request on result_out: found with the
// address base_address plus the match offset, or not-found with address zero when the
// region ends without a match. Bytes after a match produce nothing until the last byte,
// after which the block rearms for the next region.
// The user must write the configuration registers through cfg_we_i, cfg_index_i and cfg_data_i
// only while no request is in flight; the block itself does not enforce this.
// One byte is accepted every cycle unless the input is stalled. The masked compare of the
// shift window sits between the byte input and a result stage register, and the address
// add sits between that register and the output register. When the receiver stalls, the
// output register holds its request and the result stage can still take one more; input
// stalls only when both are full.
// Reset clears the window, the byte count, the match flag and the pipeline, and loads
// the register reset values.
module wildcard_byte_pattern_scanner_top #(
  parameter int unsigned MAX_PATTERN  = 16,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wbps_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  wbps_byte_if.sink                           byte_in,
  wbps_result_if.source                       result_out
);

  localparam int unsigned LEN_W = wbps_pkg::LEN_W;
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  logic [wbps_pkg::CFG_DATA_W-1:0]    pattern_low_q;
  logic [wbps_pkg::CFG_DATA_W-1:0]    pattern_high_q;
  logic [wbps_pkg::PATTERN_BYTES-1:0] care_mask_q;
  logic [LEN_W-1:0]                   pattern_length_q;
  logic [wbps_pkg::BASE_W-1:0]        base_address_q;

  logic [wbps_pkg::BYTE_W-1:0] window_q [MAX_PATTERN];
  logic [wbps_pkg::BYTE_W-1:0] window_d [MAX_PATTERN];
  logic [ADDRESS_BITS-1:0]     seen_q;
  logic                        reported_q;

  logic [2*wbps_pkg::CFG_DATA_W-1:0] pattern_all;
  logic [LEN_W-1:0]                  eff_len;
  logic [LEN_W-1:0]                  len_m1;
  logic [LEN_W-1:0]                  tap_sel [MAX_PATTERN];
  logic                              win_match;
  logic [ADDRESS_BITS-1:0]           seen_inc;
  logic [ADDRESS_BITS-1:0]           start;
  logic                              enough;
  logic                              fire;
  logic                              none;

  logic                    s1_valid_q;
  logic                    s1_found_q;
  logic [ADDRESS_BITS-1:0] s1_start_q;
  logic [ADDRESS_BITS-1:0] addr_sum;

  logic                                  out_valid_q;
  logic                                  out_found_q;
  logic [wbps_pkg::MATCH_ADDR_W-1:0]     out_addr_q;

  logic out_free;
  logic s1_free;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      care_mask_q      <= wbps_pkg::CARE_MASK_RESET;
      pattern_length_q <= wbps_pkg::PATTERN_LENGTH_RESET;
      base_address_q   <= '0;
    end else if (cfg_we_i) begin
      case (wbps_pkg::cfg_reg_e'(cfg_index_i))
        wbps_pkg::CFG_PATTERN_LOW: begin
          pattern_low_q <= cfg_data_i;
        end
        wbps_pkg::CFG_PATTERN_HIGH: begin
          pattern_high_q <= cfg_data_i;
        end
        wbps_pkg::CFG_CARE_MASK: begin
          care_mask_q <= cfg_data_i[wbps_pkg::PATTERN_BYTES-1:0];
        end
        wbps_pkg::CFG_PATTERN_LENGTH: begin
          pattern_length_q <= cfg_data_i[LEN_W-1:0];
        end
        wbps_pkg::CFG_BASE_ADDRESS: begin
          base_address_q <= cfg_data_i[wbps_pkg::BASE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign out_free      = !out_valid_q || result_out.ready;
  assign s1_free       = !s1_valid_q || out_free;
  assign byte_in.ready = s1_free;
  assign accept        = byte_in.valid && s1_free;

  assign pattern_all = {pattern_high_q, pattern_low_q};

  always_comb begin
    if (pattern_length_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length_q > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = pattern_length_q;
    end
  end

  assign len_m1 = eff_len - LEN_W'(1);

  always_comb begin
    window_d[0] = byte_in.data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_d[k] = window_q[k-1];
    end
  end

  always_comb begin
    win_match = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      tap_sel[i] = len_m1 - LEN_W'(i);
      if ((LEN_W'(i) < eff_len) && care_mask_q[i] &&
          (window_d[tap_sel[i][IDX_W-1:0]] != pattern_all[8*i +: 8])) begin
        win_match = 1'b0;
      end
    end
  end

  assign seen_inc = seen_q + ADDRESS_BITS'(1);
  assign enough   = seen_inc >= ADDRESS_BITS'(eff_len);
  assign start    = seen_q - ADDRESS_BITS'(len_m1);
  assign fire     = !reported_q && enough && win_match;
  assign none     = byte_in.last_byte && !reported_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window_q[k] <= '0;
      end
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else if (accept) begin
      if (byte_in.last_byte) begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
          window_q[k] <= '0;
        end
        seen_q     <= '0;
        reported_q <= 1'b0;
      end else begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
          window_q[k] <= window_d[k];
        end
        seen_q     <= seen_inc;
        reported_q <= reported_q || fire;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= fire || none;
    end else if (out_free) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_found_q <= fire;
      s1_start_q <= start;
    end
  end

  assign addr_sum = ADDRESS_BITS'(base_address_q) + s1_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_found_q <= s1_found_q;
      out_addr_q  <= s1_found_q ? wbps_pkg::MATCH_ADDR_W'(addr_sum) : '0;
    end
  end

  assign result_out.valid         = out_valid_q;
  assign result_out.found         = out_found_q;
  assign result_out.match_address = out_addr_q;

endmodule

// File: rtl/wbps_checker.sv
// Port-level checker for the wildcard byte pattern scanner, bound to the top level.
// Depends on wbps_pkg and wildcard_byte_pattern_scanner_top.
`timescale 1ns / 1ps

module wbps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              out_found_i,
  input logic [wbps_pkg::MATCH_ADDR_W-1:0] out_match_address_i
);

  // A not-found request always carries a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_found_i) |-> (out_match_address_i == '0))
    else $error("not-found request with nonzero address");

  // The byte input only stalls while a result request is waiting on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("byte input stalled with an empty output");

  // No result request is presented right after reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result request present right after reset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result request dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_found_i) && $stable(out_match_address_i)))
    else $error("result payload changed while stalled");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_i          (byte_in.ready),
  .out_valid_i         (result_out.valid),
  .out_ready_i         (result_out.ready),
  .out_found_i         (result_out.found),
  .out_match_address_i (result_out.match_address)
);
